FILE: hdl/tod_pkg.sv
// Shared types, widths and codes for the tilt orientation detector.
package tod_pkg;

    // Default widths of the sample and holdoff datapaths
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int HOLD_WIDTH_DEF   = 16;

    // Configuration register widths
    localparam int THR_WIDTH       = 15;
    localparam int RATIO_WIDTH     = 12;
    localparam int RATIO_FRAC_BITS = 8;
    localparam int TICKS_WIDTH     = 16;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_ADDR_WIDTH  = 2;

    // Configuration reset values
    localparam logic [THR_WIDTH-1:0]   X_THRESHOLD_RST   = 15'd7864;
    localparam logic [THR_WIDTH-1:0]   Y_THRESHOLD_RST   = 15'd7864;
    localparam logic [RATIO_WIDTH-1:0] RATIO_Q8_RST      = 12'd512;
    localparam logic [TICKS_WIDTH-1:0] HOLDOFF_TICKS_RST = 16'd1000;

    // Register indexes
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_X_THRESHOLD   = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_Y_THRESHOLD   = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_RATIO_Q8      = 2'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_HOLDOFF_TICKS = 2'd3;

    // Item commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Screen orientation codes
    typedef enum logic [1:0] {
        ORI_0   = 2'd0,
        ORI_90  = 2'd1,
        ORI_180 = 2'd2,
        ORI_270 = 2'd3
    } ori_t;

    // Outcome of the axis classification of one sample
    typedef struct packed {
        logic decided;
        ori_t pick;
    } decision_t;

endpackage

FILE: hdl/tilt_orientation_detector.sv
// An input transfer passes through the input register into the result register.
// Throughput: one item per cycle unless the result side stalls; one multiply-compare between.
// The input stage refills while a finished result waits to be taken.
// Reset (aresetn low, synchronous): orientation upright, holdoff idle, both stages
// empty, configuration registers back to their defaults.
module tilt_orientation_detector import tod_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int HOLD_WIDTH   = HOLD_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [CFG_ADDR_WIDTH-1:0]      cfg_addr,
    input  logic [CFG_DATA_WIDTH-1:0]      cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_command,
    input  logic signed [SAMPLE_WIDTH-1:0] s_x_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] s_y_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_orientation,
    output logic                           m_changed,
    output logic                           m_held_off
);

    logic [THR_WIDTH-1:0]   x_threshold_reg;
    logic [THR_WIDTH-1:0]   y_threshold_reg;
    logic [RATIO_WIDTH-1:0] ratio_q8_reg;
    logic [TICKS_WIDTH-1:0] holdoff_ticks_reg;

    logic                           advance;
    logic                           item_valid;
    logic                           item_command;
    logic signed [SAMPLE_WIDTH-1:0] item_x;
    logic signed [SAMPLE_WIDTH-1:0] item_y;
    decision_t                      decision;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_threshold_reg   <= X_THRESHOLD_RST;
            y_threshold_reg   <= Y_THRESHOLD_RST;
            ratio_q8_reg      <= RATIO_Q8_RST;
            holdoff_ticks_reg <= HOLDOFF_TICKS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_X_THRESHOLD:   x_threshold_reg   <= cfg_wdata[THR_WIDTH-1:0];
                CFG_Y_THRESHOLD:   y_threshold_reg   <= cfg_wdata[THR_WIDTH-1:0];
                CFG_RATIO_Q8:      ratio_q8_reg      <= cfg_wdata[RATIO_WIDTH-1:0];
                CFG_HOLDOFF_TICKS: holdoff_ticks_reg <= cfg_wdata[TICKS_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    tod_in_stage #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_in_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_x_sample   (s_x_sample),
        .s_y_sample   (s_y_sample),
        .advance      (advance),
        .item_valid   (item_valid),
        .item_command (item_command),
        .item_x       (item_x),
        .item_y       (item_y)
    );

    // Candidate orientation from the held sample
    tod_classify #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_classify (
        .x           (item_x),
        .y           (item_y),
        .x_threshold (x_threshold_reg),
        .y_threshold (y_threshold_reg),
        .ratio_q8    (ratio_q8_reg),
        .decision    (decision)
    );

    // State update and result register
    tod_core #(
        .HOLD_WIDTH (HOLD_WIDTH)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (item_valid),
        .item_command  (item_command),
        .decision      (decision),
        .holdoff_ticks (holdoff_ticks_reg),
        .advance       (advance),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_orientation (m_orientation),
        .m_changed     (m_changed),
        .m_held_off    (m_held_off)
    );

endmodule

FILE: hdl/tod_in_stage.sv
// Input register stage: holds one accepted item until the core takes it.
module tod_in_stage import tod_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_command,
    input  logic signed [SAMPLE_WIDTH-1:0] s_x_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] s_y_sample,
    input  logic                           advance,
    output logic                           item_valid,
    output logic                           item_command,
    output logic signed [SAMPLE_WIDTH-1:0] item_x,
    output logic signed [SAMPLE_WIDTH-1:0] item_y
);

    logic                           valid_reg;
    logic                           command_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;
    logic                           load;

    // Free when empty or when the held item moves on this cycle
    assign s_ready = !valid_reg || advance;
    assign load    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge aclk) begin
        if (load) begin
            command_reg <= s_command;
            x_reg       <= s_x_sample;
            y_reg       <= s_y_sample;
        end
    end

    assign item_valid   = valid_reg;
    assign item_command = command_reg;
    assign item_x       = x_reg;
    assign item_y       = y_reg;

endmodule

FILE: hdl/tod_classify.sv
// Axis dominance and threshold tests that pick a candidate orientation.
module tod_classify import tod_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic signed [SAMPLE_WIDTH-1:0] x,
    input  logic signed [SAMPLE_WIDTH-1:0] y,
    input  logic        [THR_WIDTH-1:0]    x_threshold,
    input  logic        [THR_WIDTH-1:0]    y_threshold,
    input  logic        [RATIO_WIDTH-1:0]  ratio_q8,
    output decision_t                      decision
);

    // Product width and a signed compare width that holds both samples and thresholds
    localparam int PW = SAMPLE_WIDTH + RATIO_WIDTH;
    localparam int CW = ((SAMPLE_WIDTH > THR_WIDTH) ? SAMPLE_WIDTH : THR_WIDTH) + 1;

    logic        [SAMPLE_WIDTH-1:0] mag_x;
    logic        [SAMPLE_WIDTH-1:0] mag_y;
    logic        [PW-1:0]           lhs;
    logic        [PW-1:0]           rhs;
    logic                           y_dominant;
    logic signed [CW-1:0]           x_ext;
    logic signed [CW-1:0]           y_ext;
    logic signed [CW-1:0]           xt_pos;
    logic signed [CW-1:0]           yt_pos;
    logic signed [CW-1:0]           xt_neg;
    logic signed [CW-1:0]           yt_neg;

    // Magnitudes; the most negative sample maps to 2^(N-1), still in N unsigned bits
    assign mag_x = x[SAMPLE_WIDTH-1] ? (~x + 1'b1) : x;
    assign mag_y = y[SAMPLE_WIDTH-1] ? (~y + 1'b1) : y;

    // |y| scaled by the Q8 point against ratio * |x|
    assign lhs = PW'({mag_y, {RATIO_FRAC_BITS{1'b0}}});
    assign rhs = PW'(ratio_q8) * PW'(mag_x);
    assign y_dominant = (lhs >= rhs);

    // Signed threshold windows
    assign x_ext  = {{(CW-SAMPLE_WIDTH){x[SAMPLE_WIDTH-1]}}, x};
    assign y_ext  = {{(CW-SAMPLE_WIDTH){y[SAMPLE_WIDTH-1]}}, y};
    assign xt_pos = signed'({{(CW-THR_WIDTH){1'b0}}, x_threshold});
    assign yt_pos = signed'({{(CW-THR_WIDTH){1'b0}}, y_threshold});
    assign xt_neg = -xt_pos;
    assign yt_neg = -yt_pos;

    always_comb begin
        decision.decided = 1'b0;
        decision.pick    = ORI_0;
        if (y_dominant) begin
            if (y_ext < yt_neg) begin
                decision.decided = 1'b1;
                decision.pick    = ORI_180;
            end else if (y_ext > yt_pos) begin
                decision.decided = 1'b1;
                decision.pick    = ORI_0;
            end
        end else begin
            if (x_ext < xt_neg) begin
                decision.decided = 1'b1;
                decision.pick    = ORI_90;
            end else if (x_ext > xt_pos) begin
                decision.decided = 1'b1;
                decision.pick    = ORI_270;
            end
        end
    end

endmodule

FILE: hdl/tod_core.sv
// Orientation and holdoff state with the result register.
module tod_core import tod_pkg::*; #(
    parameter int HOLD_WIDTH = HOLD_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   item_valid,
    input  logic                   item_command,
    input  decision_t              decision,
    input  logic [TICKS_WIDTH-1:0] holdoff_ticks,
    output logic                   advance,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_orientation,
    output logic                   m_changed,
    output logic                   m_held_off
);

    ori_t                  ori_reg;
    ori_t                  ori_next;
    logic [HOLD_WIDTH-1:0] hold_reg;
    logic [HOLD_WIDTH-1:0] hold_next;
    logic [HOLD_WIDTH-1:0] hold_load;
    logic                  changed;
    logic                  held;
    logic                  m_valid_reg;
    ori_t                  out_ori_reg;
    logic                  out_changed_reg;
    logic                  out_held_reg;

    // Item moves into the result register when that register is free or draining
    assign advance   = item_valid && (!m_valid_reg || m_ready);
    assign hold_load = HOLD_WIDTH'(holdoff_ticks);

    // Next state for the item at the head
    always_comb begin
        ori_next  = ori_reg;
        hold_next = hold_reg;
        changed   = 1'b0;
        held      = 1'b0;
        if (item_command == CMD_TICK) begin
            if (hold_reg != '0) begin
                hold_next = hold_reg - 1'b1;
            end
        end else if (hold_reg != '0) begin
            held = 1'b1;
        end else if (decision.decided && (decision.pick != ori_reg)) begin
            ori_next  = decision.pick;
            hold_next = hold_load;
            changed   = 1'b1;
        end
    end

    // State and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ori_reg     <= ORI_0;
            hold_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            ori_reg     <= ori_next;
            hold_reg    <= hold_next;
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_ori_reg     <= ori_next;
            out_changed_reg <= changed;
            out_held_reg    <= held;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_orientation = out_ori_reg;
    assign m_changed     = out_changed_reg;
    assign m_held_off    = out_held_reg;

endmodule

FILE: hdl/tod_checker.sv
// Port-level checks for the tilt orientation detector, bound to the top level.
module tod_checker import tod_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_wr_en,
    input logic [CFG_ADDR_WIDTH-1:0]      cfg_addr,
    input logic [CFG_DATA_WIDTH-1:0]      cfg_wdata,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           s_command,
    input logic signed [SAMPLE_WIDTH-1:0] s_x_sample,
    input logic signed [SAMPLE_WIDTH-1:0] s_y_sample,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [1:0]                     m_orientation,
    input logic                           m_changed,
    input logic                           m_held_off
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_orientation)
            && $stable(m_changed) && $stable(m_held_off))
        else $error("result changed while stalled");

    // A sample ignored under holdoff cannot switch orientation
    a_held_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_changed && m_held_off))
        else $error("result both held off and changed");

    // A draining result side always frees the input side
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while result side ready");

    // Leaving reset, no result is pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

bind tilt_orientation_detector tod_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_tod_checker (.*);

FILE: verif/tilt_orientation_detector_test.sv
// Self-checking testbench for the tilt orientation detector: directed table, then random phases.
`timescale 1ns / 100ps

module tilt_orientation_detector_test;
    import tod_pkg::*;

    localparam int SW          = SAMPLE_WIDTH_DEF;
    localparam int HW          = HOLD_WIDTH_DEF;
    localparam int HALF_PERIOD = 4;
    localparam int SETTLE      = 4;     // extra cycles waited once no result is pending
    localparam int RX_HOLD     = 60;    // long receiver hold-off, in cycles
    localparam int QUIET_LIMIT = 2000;  // cycles without any transfer
    localparam int N_ROWS      = 25;
    localparam int N_PHASES    = 6;

    // One expected result
    typedef struct packed {
        ori_t orientation;
        logic changed;
        logic held_off;
    } tilt_result_t;

    // One row of the directed table; typed rows carry their result
    typedef struct {
        logic                 cmd;
        logic signed [SW-1:0] x;
        logic signed [SW-1:0] y;
        bit                   typed;
        ori_t                 ori;
        logic                 changed;
        logic                 held_off;
    } tilt_row_t;

    // Table assumes thresholds 7864, ratio 2.0 and a holdoff of three ticks
    tilt_row_t directed_rows [N_ROWS] = '{
        '{CMD_TICK,   16'sd0,     16'sd0,     1'b1, ORI_0,   1'b0, 1'b0}, // straight after reset
        '{CMD_SAMPLE, 16'sd0,     16'sd0,     1'b1, ORI_0,   1'b0, 1'b0}, // both axes zero
        '{CMD_SAMPLE, 16'sd0,     16'h7FFF,   1'b1, ORI_0,   1'b0, 1'b0}, // upright again
        '{CMD_SAMPLE, 16'sd0,     16'h8000,   1'b1, ORI_180, 1'b1, 1'b0}, // flip, holdoff starts
        '{CMD_SAMPLE, 16'h7FFF,   16'sd0,     1'b1, ORI_180, 1'b0, 1'b1}, // held off
        '{CMD_TICK,   16'hFFFF,   16'hFFFF,   1'b1, ORI_180, 1'b0, 1'b0}, // tick ignores fields
        '{CMD_TICK,   16'h8000,   16'h7FFF,   1'b1, ORI_180, 1'b0, 1'b0},
        '{CMD_SAMPLE, 16'h8000,   16'sd0,     1'b1, ORI_180, 1'b0, 1'b1},
        '{CMD_TICK,   16'sd0,     16'sd0,     1'b1, ORI_180, 1'b0, 1'b0},
        '{CMD_TICK,   16'sd0,     16'sd0,     1'b1, ORI_180, 1'b0, 1'b0}, // tick at zero count
        '{CMD_SAMPLE, 16'h8000,   16'sd0,     1'b1, ORI_90,  1'b1, 1'b0}, // X decides, left
        '{CMD_TICK,   16'sd0,     16'sd0,     1'b0, ORI_0,   1'b0, 1'b0},
        '{CMD_TICK,   16'sd0,     16'sd0,     1'b0, ORI_0,   1'b0, 1'b0},
        '{CMD_TICK,   16'sd0,     16'sd0,     1'b0, ORI_0,   1'b0, 1'b0},
        '{CMD_SAMPLE, 16'h7FFF,   16'h8000,   1'b0, ORI_0,   1'b0, 1'b0}, // X wins both extremes
        '{CMD_TICK,   16'sd0,     16'sd0,     1'b0, ORI_0,   1'b0, 1'b0},
        '{CMD_TICK,   16'sd0,     16'sd0,     1'b0, ORI_0,   1'b0, 1'b0},
        '{CMD_TICK,   16'sd0,     16'sd0,     1'b0, ORI_0,   1'b0, 1'b0},
        '{CMD_SAMPLE, 16'sd7864,  16'sd0,     1'b0, ORI_0,   1'b0, 1'b0}, // on threshold
        '{CMD_SAMPLE, 16'sd7865,  16'sd100,   1'b0, ORI_0,   1'b0, 1'b0}, // same side again
        '{CMD_SAMPLE, 16'sd100,   16'sd7865,  1'b0, ORI_0,   1'b0, 1'b0},
        '{CMD_TICK,   16'sd0,     16'sd0,     1'b0, ORI_0,   1'b0, 1'b0},
        '{CMD_TICK,   16'sd0,     16'sd0,     1'b0, ORI_0,   1'b0, 1'b0},
        '{CMD_TICK,   16'sd0,     16'sd0,     1'b0, ORI_0,   1'b0, 1'b0},
        '{CMD_SAMPLE, 16'hC000,   16'h8001,   1'b0, ORI_0,   1'b0, 1'b0}  // just short of Y
    };

    // DUT ports
    logic                       aclk          = 1'b0;
    logic                       aresetn       = 1'b0;
    logic                       cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0]  cfg_addr      = CFG_X_THRESHOLD;
    logic [CFG_DATA_WIDTH-1:0]  cfg_wdata     = '0;
    logic                       s_valid       = 1'b0;
    logic                       s_ready;
    logic                       s_command     = CMD_SAMPLE;
    logic signed [SW-1:0]       s_x_sample    = '0;
    logic signed [SW-1:0]       s_y_sample    = '0;
    logic                       m_valid;
    logic                       m_ready       = 1'b0;
    logic [1:0]                 m_orientation;
    logic                       m_changed;
    logic                       m_held_off;

    // Shadow configuration and state of the detector
    logic [THR_WIDTH-1:0]       x_thr_q;
    logic [THR_WIDTH-1:0]       y_thr_q;
    logic [RATIO_WIDTH-1:0]     ratio_q;
    logic [TICKS_WIDTH-1:0]     hold_ticks_q;
    ori_t                       ori_q;
    logic [HW-1:0]              hold_cnt_q;

    tilt_result_t               pending_results[$];
    bit                         calm        = 1'b0;
    bit                         rx_hold_req = 1'b0;
    int                         mismatches   = 0;
    int                         items_sent   = 0;
    int                         results_seen = 0;
    int                         changes_seen = 0;
    int                         held_seen    = 0;

    tilt_orientation_detector i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_x_sample    (s_x_sample),
        .s_y_sample    (s_y_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_orientation (m_orientation),
        .m_changed     (m_changed),
        .m_held_off    (m_held_off)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Predict the result of one item and advance the shadow state
    function automatic tilt_result_t step_detector(logic cmd, logic signed [SW-1:0] x,
                                                   logic signed [SW-1:0] y);
        tilt_result_t r;
        int           xi;
        int           yi;
        int           ax;
        int           ay;
        bit           decided;
        ori_t         pick;
        r.changed  = 1'b0;
        r.held_off = 1'b0;
        decided    = 1'b0;
        pick       = ORI_0;
        if (cmd == CMD_TICK) begin
            if (hold_cnt_q != '0) hold_cnt_q = hold_cnt_q - 1'b1;
        end else if (hold_cnt_q != '0) begin
            r.held_off = 1'b1;
        end else begin
            xi = x;
            yi = y;
            ax = (xi < 0) ? -xi : xi;
            ay = (yi < 0) ? -yi : yi;
            if (ay * 256 >= int'(ratio_q) * ax) begin
                if (yi < -int'(y_thr_q)) begin
                    pick = ORI_180; decided = 1'b1;
                end else if (yi > int'(y_thr_q)) begin
                    pick = ORI_0; decided = 1'b1;
                end
            end else begin
                if (xi < -int'(x_thr_q)) begin
                    pick = ORI_90; decided = 1'b1;
                end else if (xi > int'(x_thr_q)) begin
                    pick = ORI_270; decided = 1'b1;
                end
            end
            if (decided && pick != ori_q) begin
                ori_q      = pick;
                hold_cnt_q = HW'(hold_ticks_q);
                r.changed  = 1'b1;
            end
        end
        r.orientation = ori_q;
        return r;
    endfunction

    function automatic logic signed [SW-1:0] to_s16(int v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return SW'(v);
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Register write at the falling edge, shadow copy kept in step
    task automatic write_reg(logic [CFG_ADDR_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        case (idx)
            CFG_X_THRESHOLD:   x_thr_q      = val[THR_WIDTH-1:0];
            CFG_Y_THRESHOLD:   y_thr_q      = val[THR_WIDTH-1:0];
            CFG_RATIO_Q8:      ratio_q      = val[RATIO_WIDTH-1:0];
            CFG_HOLDOFF_TICKS: hold_ticks_q = val[TICKS_WIDTH-1:0];
            default: ;
        endcase
    endtask

    // Full register set; unused upper data bits carry junk
    task automatic apply_setting(int xt, int yt, int ratio, int ticks);
        write_reg(CFG_X_THRESHOLD, {1'($urandom), THR_WIDTH'(xt)});
        write_reg(CFG_Y_THRESHOLD, {1'($urandom), THR_WIDTH'(yt)});
        write_reg(CFG_RATIO_Q8,    {4'($urandom), RATIO_WIDTH'(ratio)});
        write_reg(CFG_HOLDOFF_TICKS, TICKS_WIDTH'(ticks));
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one item; the expectation is queued at the transfer edge
    task automatic offer(logic cmd, logic signed [SW-1:0] x, logic signed [SW-1:0] y,
                         bit typed, tilt_result_t typed_res);
        tilt_result_t pred;
        while (!calm && $urandom_range(99) < 33) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_x_sample <= x;
        s_y_sample <= y;
        do @(posedge aclk); while (!s_ready);
        pred = step_detector(cmd, x, y);
        pending_results.push_back(typed ? typed_res : pred);
        items_sent++;
        @(negedge aclk);
    endtask

    // Stop offering and let every result come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Random item: mostly samples aimed at thresholds and the dominance line
    task automatic make_item(output logic cmd, output logic signed [SW-1:0] x,
                             output logic signed [SW-1:0] y);
        int pick;
        int ax;
        int ay;
        pick = $urandom_range(99);
        cmd  = CMD_SAMPLE;
        x    = SW'($urandom);
        y    = SW'($urandom);
        if (pick < 35) begin
            cmd = CMD_TICK;
        end else if (pick < 50) begin
            // full-range noise
        end else if (pick < 62) begin
            ax = int'(x_thr_q) + $urandom_range(2) - 1;
            x  = to_s16($urandom_range(1) ? ax : -ax);
            y  = to_s16($urandom_range(600) - 300);
        end else if (pick < 74) begin
            ay = int'(y_thr_q) + $urandom_range(2) - 1;
            y  = to_s16($urandom_range(1) ? ay : -ay);
            x  = to_s16($urandom_range(600) - 300);
        end else if (pick < 86) begin
            ax = $urandom_range(4000);
            ay = (int'(ratio_q) * ax) / 256 + $urandom_range(2) - 1;
            if (ay < 0) ay = 0;
            x  = to_s16($urandom_range(1) ? ax : -ax);
            y  = to_s16($urandom_range(1) ? ay : -ay);
        end else begin
            case ($urandom_range(4))
                0: x = 16'h8000;
                1: x = 16'h7FFF;
                2: x = 16'sd0;
                3: x = -16'sd1;
                default: x = 16'sd1;
            endcase
            case ($urandom_range(4))
                0: y = 16'h8000;
                1: y = 16'h7FFF;
                2: y = 16'sd0;
                3: y = -16'sd1;
                default: y = 16'sd1;
            endcase
        end
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request
    initial begin : receiver
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD) @(negedge aclk);
            end
            m_ready <= calm || ($urandom_range(99) >= 33);
        end
    end

    // Result checker against the oldest expectation
    always @(posedge aclk) begin : result_check
        tilt_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_changed === 1'b1) changes_seen++;
            if (m_held_off === 1'b1) held_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result", m_orientation, -1);
            end else begin
                want = pending_results.pop_front();
                if (m_orientation !== want.orientation)
                    flag_mismatch("orientation", m_orientation, want.orientation);
                if (m_changed !== want.changed)
                    flag_mismatch("changed", m_changed, want.changed);
                if (m_held_off !== want.held_off)
                    flag_mismatch("held_off", m_held_off, want.held_off);
            end
        end
    end

    // Watchdog on cycles without any transfer
    initial begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge aresetn);
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("timeout after %0d cycles without a transfer", QUIET_LIMIT);
        $display("** tilt_orientation_detector: FAILED **");
        $finish;
    end

    initial begin : stimulus
        logic                 cmd;
        logic signed [SW-1:0] xs;
        logic signed [SW-1:0] ys;
        tilt_result_t         row_res;
        int                   phase_items [N_PHASES];
        phase_items  = '{110, 110, 110, 110, 50, 110};
        x_thr_q      = X_THRESHOLD_RST;
        y_thr_q      = Y_THRESHOLD_RST;
        ratio_q      = RATIO_Q8_RST;
        hold_ticks_q = HOLDOFF_TICKS_RST;
        ori_q        = ORI_0;
        hold_cnt_q   = '0;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table at default thresholds, short holdoff
        apply_setting(X_THRESHOLD_RST, Y_THRESHOLD_RST, RATIO_Q8_RST, 3);
        @(negedge aclk);
        foreach (directed_rows[i]) begin
            row_res.orientation = directed_rows[i].ori;
            row_res.changed     = directed_rows[i].changed;
            row_res.held_off    = directed_rows[i].held_off;
            offer(directed_rows[i].cmd, directed_rows[i].x, directed_rows[i].y,
                  directed_rows[i].typed, row_res);
        end

        // Random phases, each under its own register setting
        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            calm = (p == 2);
            case (p)
                0: apply_setting(7864, 7864, 512, 4);
                1: apply_setting(0, 0, 0, 0);               // ratio zero, no holdoff
                2: apply_setting(32767, 32767, 4095, 2);    // threshold and ratio maxima
                3: apply_setting($urandom_range(20000, 1000), $urandom_range(20000, 1000),
                                 $urandom_range(4095), $urandom_range(6, 1));
                4: apply_setting(500, 9000, 256, 65535);    // longest holdoff
                default: apply_setting($urandom_range(32767), $urandom_range(32767),
                                       $urandom_range(4095), $urandom_range(3));
            endcase
            @(negedge aclk);
            for (int n = 0; n < phase_items[p]; n++) begin
                if (p == 1 && n == 30) begin
                    // long receiver hold-off while items keep coming
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    rx_hold_req = 1'b1;
                    @(negedge aclk);
                end
                if (p == 1 && n == 80) begin
                    // sender waits for everything outstanding
                    s_valid <= 1'b0;
                    while (pending_results.size() != 0) @(posedge aclk);
                    @(negedge aclk);
                end
                make_item(cmd, xs, ys);
                offer(cmd, xs, ys, 1'b0, row_res);
            end
        end

        wait_idle();
        if (pending_results.size() != 0)
            flag_mismatch("results never delivered", 0, pending_results.size());

        $display("Covered %0d items (%0d from the table) over %0d register settings.",
                 items_sent, N_ROWS, N_PHASES + 1);
        $display("Saw %0d results: %0d orientation changes, %0d held-off samples, %0d errors.",
                 results_seen, changes_seen, held_seen, mismatches);
        if (mismatches == 0) begin
            $display("** tilt_orientation_detector: PASSED **");
        end else begin
            $display("** tilt_orientation_detector: FAILED **");
        end
        $finish;
    end

endmodule
